[hdl/crc_pkg.sv]
// Shared types and codes for the circle/rectangle overlap pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package crc_pkg;

	localparam logic SHAPE_CIRCLE = 1'b0;

	localparam logic [1:0] KIND_CC   = 2'd0;
	localparam logic [1:0] KIND_CR   = 2'd1;
	localparam logic [1:0] KIND_RR   = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic       rr_hit;
	} ctl_t;

endpackage

`default_nettype wire

[hdl/circle_rect_collision_test_top.sv]
// Top level of the circle/rectangle overlap test pipeline.
// Depends on crc_pkg, crc_setup, crc_span and crc_square.
//
// Usage:
//   A pair is transferred at a rising edge where start is high and busy is
//   low. busy stays low: the pipeline takes one pair every cycle.
//   Each result appears on collided and test_kind for one cycle with done
//   high; results leave in transfer order.
//   The receiver cannot stall, so no pipeline stage ever holds.
//   Stages: role select and bounds, clamp and box test, distance magnitude,
//   two squarer stages (half-width partial products), sum and compare.
//   Throughput is one pair per cycle.
//   Reset (arst_n low) clears every valid bit; pairs in flight are dropped.
//   Positions are COORD_WIDTH-bit two's complement, sizes COORD_WIDTH-1 bits.
`default_nettype none

module circle_rect_collision_test_top import crc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     pair_eligible,
	input  wire logic                     shape_a,
	input  wire logic [COORD_WIDTH-1:0]   pos_a_x,
	input  wire logic [COORD_WIDTH-1:0]   pos_a_z,
	input  wire logic [COORD_WIDTH-2:0]   size_a_x,
	input  wire logic [COORD_WIDTH-2:0]   size_a_y,
	input  wire logic                     shape_b,
	input  wire logic [COORD_WIDTH-1:0]   pos_b_x,
	input  wire logic [COORD_WIDTH-1:0]   pos_b_z,
	input  wire logic [COORD_WIDTH-2:0]   size_b_x,
	input  wire logic [COORD_WIDTH-2:0]   size_b_y,
	output logic                          done,
	output logic                          collided,
	output logic [1:0]                    test_kind
);

	localparam int W  = COORD_WIDTH;
	localparam int MW = W + 3;

	ctl_t                ctl_s1, ctl_s3, ctl_s4, ctl_s5;
	logic signed [W+1:0] px_s1, pz_s1, lox_s1, hix_s1, loz_s1, hiz_s1;
	logic signed [W+1:0] la_x_s1, ua_x_s1, la_z_s1, ua_z_s1;
	logic signed [W+1:0] lb_x_s1, ub_x_s1, lb_z_s1, ub_z_s1;
	logic [W:0]          rd_s1, rd_s3;
	logic [MW-1:0]       magx_s3, magz_s3;
	logic [2*MW-1:0]     sqx_s5, sqz_s5, sqr_s5;
	logic [2*MW:0]       sq_sum;
	logic                hit;
	logic                done_s6, collided_s6;
	logic [1:0]          kind_s6;

	assign busy = 1'b0;

	crc_setup #(.W(W)) u_setup (
		.clk(clk), .arst_n(arst_n), .in_valid(start & ~busy),
		.pair_eligible(pair_eligible), .shape_a(shape_a),
		.pos_a_x(pos_a_x), .pos_a_z(pos_a_z), .size_a_x(size_a_x), .size_a_y(size_a_y),
		.shape_b(shape_b),
		.pos_b_x(pos_b_x), .pos_b_z(pos_b_z), .size_b_x(size_b_x), .size_b_y(size_b_y),
		.ctl_s1(ctl_s1), .px_s1(px_s1), .pz_s1(pz_s1),
		.lox_s1(lox_s1), .hix_s1(hix_s1), .loz_s1(loz_s1), .hiz_s1(hiz_s1),
		.la_x_s1(la_x_s1), .ua_x_s1(ua_x_s1), .la_z_s1(la_z_s1), .ua_z_s1(ua_z_s1),
		.lb_x_s1(lb_x_s1), .ub_x_s1(ub_x_s1), .lb_z_s1(lb_z_s1), .ub_z_s1(ub_z_s1),
		.rd_s1(rd_s1)
	);

	crc_span #(.W(W)) u_span (
		.clk(clk), .arst_n(arst_n), .ctl_s1(ctl_s1),
		.px_s1(px_s1), .pz_s1(pz_s1),
		.lox_s1(lox_s1), .hix_s1(hix_s1), .loz_s1(loz_s1), .hiz_s1(hiz_s1),
		.la_x_s1(la_x_s1), .ua_x_s1(ua_x_s1), .la_z_s1(la_z_s1), .ua_z_s1(ua_z_s1),
		.lb_x_s1(lb_x_s1), .ub_x_s1(ub_x_s1), .lb_z_s1(lb_z_s1), .ub_z_s1(ub_z_s1),
		.rd_s1(rd_s1),
		.ctl_s3(ctl_s3), .magx_s3(magx_s3), .magz_s3(magz_s3), .rd_s3(rd_s3)
	);

	crc_square #(.MW(MW)) u_sq_x (.clk(clk), .mag(magx_s3), .sq_s2(sqx_s5));
	crc_square #(.MW(MW)) u_sq_z (.clk(clk), .mag(magz_s3), .sq_s2(sqz_s5));
	crc_square #(.MW(MW)) u_sq_r (.clk(clk), .mag({2'b00, rd_s3}), .sq_s2(sqr_s5));

	always_comb begin
		sq_sum = {1'b0, sqx_s5} + {1'b0, sqz_s5};
		hit    = (sq_sum <= {1'b0, sqr_s5});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			done_s6 <= 1'b0;
		end else begin
			ctl_s4  <= ctl_s3;
			ctl_s5  <= ctl_s4;
			done_s6 <= ctl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s6 <= ctl_s5.kind;
		unique case (ctl_s5.kind)
			KIND_CC, KIND_CR: collided_s6 <= hit;
			KIND_RR:          collided_s6 <= ctl_s5.rr_hit;
			default:          collided_s6 <= 1'b0;
		endcase
	end

	assign done      = done_s6;
	assign collided  = collided_s6;
	assign test_kind = kind_s6;

	a_done_has_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result without a transfer six cycles earlier");

	a_transfer_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("transfer without a result six cycles later");

	a_ineligible_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && test_kind == KIND_NONE) |-> !collided)
		else $error("ineligible pair reported as collided");

endmodule

`default_nettype wire

[hdl/crc_setup.sv]
// Stage 1: role selection, doubled coordinates and box bounds.
// Depends on crc_pkg.
`default_nettype none

module crc_setup import crc_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  pair_eligible,
	input  wire logic                  shape_a,
	input  wire logic [W-1:0]          pos_a_x,
	input  wire logic [W-1:0]          pos_a_z,
	input  wire logic [W-2:0]          size_a_x,
	input  wire logic [W-2:0]          size_a_y,
	input  wire logic                  shape_b,
	input  wire logic [W-1:0]          pos_b_x,
	input  wire logic [W-1:0]          pos_b_z,
	input  wire logic [W-2:0]          size_b_x,
	input  wire logic [W-2:0]          size_b_y,
	output ctl_t                       ctl_s1,
	output logic signed [W+1:0]        px_s1,
	output logic signed [W+1:0]        pz_s1,
	output logic signed [W+1:0]        lox_s1,
	output logic signed [W+1:0]        hix_s1,
	output logic signed [W+1:0]        loz_s1,
	output logic signed [W+1:0]        hiz_s1,
	output logic signed [W+1:0]        la_x_s1,
	output logic signed [W+1:0]        ua_x_s1,
	output logic signed [W+1:0]        la_z_s1,
	output logic signed [W+1:0]        ua_z_s1,
	output logic signed [W+1:0]        lb_x_s1,
	output logic signed [W+1:0]        ub_x_s1,
	output logic signed [W+1:0]        lb_z_s1,
	output logic signed [W+1:0]        ub_z_s1,
	output logic [W:0]                 rd_s1
);

	logic signed [W+1:0] ax2, az2, bx2, bz2;
	logic signed [W+1:0] aw, ah, bw, bh;
	logic signed [W+1:0] cx2, cz2, ox2, oz2, ow, oh;
	logic        [W-2:0] c_r, o_r;
	logic        [W-1:0] r_sum;
	logic                swap, other_circle;
	logic        [1:0]   kind;

	always_comb begin
		ax2 = $signed({pos_a_x[W-1], pos_a_x, 1'b0});
		az2 = $signed({pos_a_z[W-1], pos_a_z, 1'b0});
		bx2 = $signed({pos_b_x[W-1], pos_b_x, 1'b0});
		bz2 = $signed({pos_b_z[W-1], pos_b_z, 1'b0});
		aw  = $signed({3'b000, size_a_x});
		ah  = $signed({3'b000, size_a_y});
		bw  = $signed({3'b000, size_b_x});
		bh  = $signed({3'b000, size_b_y});

		swap         = (shape_a != SHAPE_CIRCLE);
		other_circle = swap ? (shape_a == SHAPE_CIRCLE) : (shape_b == SHAPE_CIRCLE);
		cx2 = swap ? bx2 : ax2;
		cz2 = swap ? bz2 : az2;
		c_r = swap ? size_b_x : size_a_x;
		ox2 = swap ? ax2 : bx2;
		oz2 = swap ? az2 : bz2;
		o_r = swap ? size_a_x : size_b_x;
		ow  = other_circle ? '0 : (swap ? aw : bw);
		oh  = other_circle ? '0 : (swap ? ah : bh);
		r_sum = {1'b0, c_r} + (other_circle ? {1'b0, o_r} : '0);

		priority if (!pair_eligible) begin
			kind = KIND_NONE;
		end else if (shape_a == SHAPE_CIRCLE && shape_b == SHAPE_CIRCLE) begin
			kind = KIND_CC;
		end else if (shape_a == SHAPE_CIRCLE || shape_b == SHAPE_CIRCLE) begin
			kind = KIND_CR;
		end else begin
			kind = KIND_RR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.kind   <= kind;
			ctl_s1.rr_hit <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= cx2;
		pz_s1   <= cz2;
		lox_s1  <= ox2 - ow;
		hix_s1  <= ox2 + ow;
		loz_s1  <= oz2 - oh;
		hiz_s1  <= oz2 + oh;
		la_x_s1 <= ax2 - aw;
		ua_x_s1 <= ax2 + aw;
		la_z_s1 <= az2 - ah;
		ua_z_s1 <= az2 + ah;
		lb_x_s1 <= bx2 - bw;
		ub_x_s1 <= bx2 + bw;
		lb_z_s1 <= bz2 - bh;
		ub_z_s1 <= bz2 + bh;
		rd_s1   <= {r_sum, 1'b0};
	end

endmodule

`default_nettype wire

[hdl/crc_span.sv]
// Stages 2 and 3: clamp to the box, box overlap test, distance magnitudes.
// Depends on crc_pkg.
`default_nettype none

module crc_span import crc_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_t                  ctl_s1,
	input  wire logic signed [W+1:0]   px_s1,
	input  wire logic signed [W+1:0]   pz_s1,
	input  wire logic signed [W+1:0]   lox_s1,
	input  wire logic signed [W+1:0]   hix_s1,
	input  wire logic signed [W+1:0]   loz_s1,
	input  wire logic signed [W+1:0]   hiz_s1,
	input  wire logic signed [W+1:0]   la_x_s1,
	input  wire logic signed [W+1:0]   ua_x_s1,
	input  wire logic signed [W+1:0]   la_z_s1,
	input  wire logic signed [W+1:0]   ua_z_s1,
	input  wire logic signed [W+1:0]   lb_x_s1,
	input  wire logic signed [W+1:0]   ub_x_s1,
	input  wire logic signed [W+1:0]   lb_z_s1,
	input  wire logic signed [W+1:0]   ub_z_s1,
	input  wire logic [W:0]            rd_s1,
	output ctl_t                       ctl_s3,
	output logic [W+2:0]               magx_s3,
	output logic [W+2:0]               magz_s3,
	output logic [W:0]                 rd_s3
);

	ctl_t                ctl_s2;
	logic signed [W+1:0] px_s2, pz_s2, nx_s2, nz_s2;
	logic        [W:0]   rd_s2;
	logic signed [W+1:0] nx, nz;
	logic signed [W+2:0] dxp, dxn, dzp, dzn;
	logic                rr_hit;

	always_comb begin
		nx = (px_s1 <= lox_s1) ? lox_s1 : ((px_s1 >= hix_s1) ? hix_s1 : px_s1);
		nz = (pz_s1 <= loz_s1) ? loz_s1 : ((pz_s1 >= hiz_s1) ? hiz_s1 : pz_s1);
		rr_hit = (la_x_s1 < ub_x_s1) && (lb_x_s1 < ua_x_s1)
			&& (la_z_s1 < ub_z_s1) && (lb_z_s1 < ua_z_s1);
		dxp = {px_s2[W+1], px_s2} - {nx_s2[W+1], nx_s2};
		dxn = {nx_s2[W+1], nx_s2} - {px_s2[W+1], px_s2};
		dzp = {pz_s2[W+1], pz_s2} - {nz_s2[W+1], nz_s2};
		dzn = {nz_s2[W+1], nz_s2} - {pz_s2[W+1], pz_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= '{valid: ctl_s1.valid, kind: ctl_s1.kind, rr_hit: rr_hit};
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s2   <= px_s1;
		pz_s2   <= pz_s1;
		nx_s2   <= nx;
		nz_s2   <= nz;
		rd_s2   <= rd_s1;
		magx_s3 <= dxp[W+2] ? dxn : dxp;
		magz_s3 <= dzp[W+2] ? dzn : dzp;
		rd_s3   <= rd_s2;
	end

endmodule

`default_nettype wire

[hdl/crc_square.sv]
// Two-stage squarer: registered half-width partial products, then their sum.
// No dependencies beyond crc_pkg.
`default_nettype none

module crc_square import crc_pkg::*; #(
	parameter int MW = 35
) (
	input  wire logic            clk,
	input  wire logic [MW-1:0]   mag,
	output logic [2*MW-1:0]      sq_s2
);

	localparam int L = (MW + 1) / 2;
	localparam int H = MW - L;

	logic [L-1:0]     lo;
	logic [H-1:0]     hi;
	logic [2*L-1:0]   ll_s1;
	logic [MW-1:0]    lh_s1;
	logic [2*H-1:0]   hh_s1;

	assign lo = mag[L-1:0];
	assign hi = mag[MW-1:L];

	always_ff @(posedge clk) begin
		ll_s1 <= lo * lo;
		lh_s1 <= lo * hi;
		hh_s1 <= hi * hi;
		sq_s2 <= {{(2*MW-2*L){1'b0}}, ll_s1}
			+ ({{MW{1'b0}}, lh_s1} << (L + 1))
			+ {hh_s1, {(2*L){1'b0}}};
	end

endmodule

`default_nettype wire

[dv/tb_circle_rect_collision_test_top.sv]
`timescale 1ns / 1ps
// Testbench for circle_rect_collision_test_top: directed and random shape pairs,
// checked against an exact in-bench overlap predictor. Depends on crc_pkg and the RTL.

module tb_circle_rect_collision_test_top;
	import crc_pkg::*;

	localparam int CW = 32;
	localparam int ONE = 65536;
	localparam logic SHAPE_RECT = ~SHAPE_CIRCLE;
	localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] POS_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-2:0] SIZE_MAX = '1;

	typedef struct {
		logic          elig;
		logic          shape_a;
		logic [CW-1:0] ax, az;
		logic [CW-2:0] aw, ah;
		logic          shape_b;
		logic [CW-1:0] bx, bz;
		logic [CW-2:0] bw, bh;
	} pair_t;

	typedef struct {
		logic       collided;
		logic [1:0] kind;
	} outcome_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic          pair_eligible = 1'b0;
	logic          shape_a = 1'b0;
	logic [CW-1:0] pos_a_x = '0;
	logic [CW-1:0] pos_a_z = '0;
	logic [CW-2:0] size_a_x = '0;
	logic [CW-2:0] size_a_y = '0;
	logic          shape_b = 1'b0;
	logic [CW-1:0] pos_b_x = '0;
	logic [CW-1:0] pos_b_z = '0;
	logic [CW-2:0] size_b_x = '0;
	logic [CW-2:0] size_b_y = '0;
	logic          done;
	logic          collided;
	logic [1:0]    test_kind;

	outcome_t pending_outcomes[$];
	outcome_t oldest;
	int       n_errors = 0;
	bit       no_idle = 1'b0;

	circle_rect_collision_test_top #(.COORD_WIDTH(CW)) uut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [95:0] square_mag(input logic signed [47:0] v);
		logic [47:0] m;
		m = v[47] ? 48'(-v) : 48'(v);
		return 96'(m) * 96'(m);
	endfunction

	function automatic logic signed [47:0] clamp_to(input logic signed [47:0] v,
			input logic signed [47:0] lo, input logic signed [47:0] hi);
		if (v <= lo)
			return lo;
		if (v >= hi)
			return hi;
		return v;
	endfunction

	// doubled units: box edges are 2*centre +/- size
	function automatic logic circle_box_hit(input logic signed [47:0] cx, cz, r,
			input logic signed [47:0] rx, rz, w, h);
		logic signed [47:0] px, pz, nx, nz;
		px = 2 * cx;
		pz = 2 * cz;
		nx = clamp_to(px, 2 * rx - w, 2 * rx + w);
		nz = clamp_to(pz, 2 * rz - h, 2 * rz + h);
		return (square_mag(px - nx) + square_mag(pz - nz)) <= square_mag(2 * r);
	endfunction

	function automatic outcome_t predict_overlap(input pair_t p);
		outcome_t o;
		logic signed [47:0] xa, za, wa, ha, xb, zb, wb, hb;
		xa = {{(48-CW){p.ax[CW-1]}}, p.ax};
		za = {{(48-CW){p.az[CW-1]}}, p.az};
		xb = {{(48-CW){p.bx[CW-1]}}, p.bx};
		zb = {{(48-CW){p.bz[CW-1]}}, p.bz};
		wa = {{(49-CW){1'b0}}, p.aw};
		ha = {{(49-CW){1'b0}}, p.ah};
		wb = {{(49-CW){1'b0}}, p.bw};
		hb = {{(49-CW){1'b0}}, p.bh};
		if (!p.elig) begin
			o.collided = 1'b0;
			o.kind = KIND_NONE;
		end else if (p.shape_a == SHAPE_CIRCLE && p.shape_b == SHAPE_CIRCLE) begin
			o.kind = KIND_CC;
			o.collided = (square_mag(xa - xb) + square_mag(za - zb)) <= square_mag(wa + wb);
		end else if (p.shape_a == SHAPE_CIRCLE) begin
			o.kind = KIND_CR;
			o.collided = circle_box_hit(xa, za, wa, xb, zb, wb, hb);
		end else if (p.shape_b == SHAPE_CIRCLE) begin
			o.kind = KIND_CR;
			o.collided = circle_box_hit(xb, zb, wb, xa, za, wa, ha);
		end else begin
			o.kind = KIND_RR;
			o.collided = (2 * xa - wa < 2 * xb + wb) && (2 * xb - wb < 2 * xa + wa) &&
				(2 * za - ha < 2 * zb + hb) && (2 * zb - hb < 2 * za + ha);
		end
		return o;
	endfunction

	function automatic pair_t mk(input logic elig, input logic sa,
			input logic [CW-1:0] ax, az, input logic [CW-2:0] aw, ah, input logic sb,
			input logic [CW-1:0] bx, bz, input logic [CW-2:0] bw, bh);
		pair_t p;
		p.elig = elig;
		p.shape_a = sa;
		p.ax = ax;
		p.az = az;
		p.aw = aw;
		p.ah = ah;
		p.shape_b = sb;
		p.bx = bx;
		p.bz = bz;
		p.bw = bw;
		p.bh = bh;
		return p;
	endfunction

	function automatic logic [CW-1:0] pick_pos();
		case ($urandom_range(0, 4))
			0: return POS_MIN;
			1: return POS_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CW-2:0] pick_size();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return SIZE_MAX;
			2: return 1;
			default: return $urandom;
		endcase
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_pair(input pair_t p);
		int unsigned gap;
		bit taken;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pair_eligible <= p.elig;
		shape_a <= p.shape_a;
		pos_a_x <= p.ax;
		pos_a_z <= p.az;
		size_a_x <= p.aw;
		size_a_y <= p.ah;
		shape_b <= p.shape_b;
		pos_b_x <= p.bx;
		pos_b_z <= p.bz;
		size_b_x <= p.bw;
		size_b_y <= p.bh;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		pending_outcomes.push_back(predict_overlap(p));
	endtask

	always @(negedge clk) begin
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result with nothing expected: collided %0d kind %0d",
					$time, collided, test_kind);
				n_errors++;
			end else begin
				oldest = pending_outcomes.pop_front();
				if (collided !== oldest.collided) begin
					$display("%0t: collided expected %0d actual %0d",
						$time, oldest.collided, collided);
					n_errors++;
				end
				if (test_kind !== oldest.kind) begin
					$display("%0t: test_kind expected %0d actual %0d",
						$time, oldest.kind, test_kind);
					n_errors++;
				end
			end
		end
	end

	task automatic test_not_eligible();
		send_pair(mk(1'b0, SHAPE_CIRCLE, 0, 0, ONE, ONE, SHAPE_CIRCLE, 0, 0, ONE, ONE));
		send_pair(mk(1'b0, SHAPE_RECT, '1, '1, SIZE_MAX, SIZE_MAX,
			SHAPE_RECT, '1, '1, SIZE_MAX, SIZE_MAX));
	endtask

	task automatic test_circle_circle();
		send_pair(mk(1'b1, SHAPE_CIRCLE, ONE, -ONE, 0, 0, SHAPE_CIRCLE, ONE, -ONE, 0, 0));
		send_pair(mk(1'b1, SHAPE_CIRCLE, 0, 0, 2 * ONE, 0,
			SHAPE_CIRCLE, 3 * ONE, 4 * ONE, 3 * ONE, 0));
		send_pair(mk(1'b1, SHAPE_CIRCLE, 0, 0, 2 * ONE, 0,
			SHAPE_CIRCLE, 3 * ONE, 4 * ONE, 3 * ONE - 1, 0));
		send_pair(mk(1'b1, SHAPE_CIRCLE, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
			SHAPE_CIRCLE, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX));
		send_pair(mk(1'b1, SHAPE_CIRCLE, POS_MIN, POS_MAX, 0, SIZE_MAX,
			SHAPE_CIRCLE, POS_MIN, POS_MAX, 0, 0));
	endtask

	task automatic test_circle_rect();
		send_pair(mk(1'b1, SHAPE_CIRCLE, 0, 0, ONE, 0,
			SHAPE_RECT, 3 * ONE, 0, 4 * ONE, 2 * ONE));
		send_pair(mk(1'b1, SHAPE_RECT, 3 * ONE, 0, 4 * ONE, 2 * ONE,
			SHAPE_CIRCLE, 0, 0, ONE, 0));
		send_pair(mk(1'b1, SHAPE_CIRCLE, 0, 0, ONE - 1, 0,
			SHAPE_RECT, 3 * ONE, 0, 4 * ONE, 2 * ONE));
		send_pair(mk(1'b1, SHAPE_CIRCLE, 0, 0, 5 * ONE, 0,
			SHAPE_RECT, 5 * ONE, 4 * ONE, 2 * ONE, 2 * ONE));
		send_pair(mk(1'b1, SHAPE_RECT, 5 * ONE, 4 * ONE, 2 * ONE, 2 * ONE,
			SHAPE_CIRCLE, 0, 0, 5 * ONE - 1, 0));
		send_pair(mk(1'b1, SHAPE_CIRCLE, ONE / 2, -ONE / 2, 0, 0,
			SHAPE_RECT, 0, 0, 2 * ONE, 2 * ONE));
		send_pair(mk(1'b1, SHAPE_RECT, 7, 7, 0, 0, SHAPE_CIRCLE, 7, 7, 0, 0));
		send_pair(mk(1'b1, SHAPE_CIRCLE, POS_MAX, POS_MAX, SIZE_MAX, 0,
			SHAPE_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX));
	endtask

	task automatic test_rect_rect();
		send_pair(mk(1'b1, SHAPE_RECT, 0, 0, 2 * ONE, 2 * ONE,
			SHAPE_RECT, 2 * ONE, 0, 2 * ONE, 2 * ONE));
		send_pair(mk(1'b1, SHAPE_RECT, 0, 0, 2 * ONE, 2 * ONE,
			SHAPE_RECT, 2 * ONE - 1, 0, 2 * ONE, 2 * ONE));
		send_pair(mk(1'b1, SHAPE_RECT, 0, 0, 0, 2 * ONE,
			SHAPE_RECT, 0, 0, 2 * ONE, 2 * ONE));
		send_pair(mk(1'b1, SHAPE_RECT, 0, 0, 1, 1, SHAPE_RECT, 1, 0, 1, 1));
		send_pair(mk(1'b1, SHAPE_RECT, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX,
			SHAPE_RECT, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX));
		send_pair(mk(1'b1, SHAPE_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
			SHAPE_RECT, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX));
	endtask

	task automatic test_random(input int count);
		pair_t p;
		int ea, eb, off, other;
		bit along_z;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			p.elig = ($urandom_range(0, 9) != 0);
			p.shape_a = $urandom_range(0, 1);
			p.shape_b = $urandom_range(0, 1);
			case ($urandom_range(0, 9))
				0, 1: begin
					p.ax = $urandom;
					p.az = $urandom;
					p.aw = $urandom;
					p.ah = $urandom;
					p.bx = $urandom;
					p.bz = $urandom;
					p.bw = $urandom;
					p.bh = $urandom;
				end
				2: begin
					p.ax = pick_pos();
					p.az = pick_pos();
					p.aw = pick_size();
					p.ah = pick_size();
					p.bx = pick_pos();
					p.bz = pick_pos();
					p.bw = pick_size();
					p.bh = pick_size();
				end
				3, 4, 5: begin
					p.ax = $urandom;
					p.az = $urandom;
					p.aw = $urandom_range(0, 1 << 20);
					p.ah = $urandom_range(0, 1 << 20);
					p.bw = $urandom_range(0, 1 << 20);
					p.bh = $urandom_range(0, 1 << 20);
					p.bx = p.ax + int'($urandom_range(0, 1 << 21)) - (1 << 20);
					p.bz = p.az + int'($urandom_range(0, 1 << 21)) - (1 << 20);
				end
				default: begin
					// place the shapes at touching distance on one axis, then nudge
					p.ax = int'($urandom_range(0, 1 << 28)) - (1 << 27);
					p.az = int'($urandom_range(0, 1 << 28)) - (1 << 27);
					p.aw = $urandom_range(0, 1 << 18);
					p.ah = $urandom_range(0, 1 << 18);
					p.bw = $urandom_range(0, 1 << 18);
					p.bh = $urandom_range(0, 1 << 18);
					along_z = $urandom_range(0, 1);
					ea = (p.shape_a == SHAPE_CIRCLE) ? 2 * int'(p.aw) :
						(along_z ? int'(p.ah) : int'(p.aw));
					eb = (p.shape_b == SHAPE_CIRCLE) ? 2 * int'(p.bw) :
						(along_z ? int'(p.bh) : int'(p.bw));
					off = (ea + eb) / 2 + int'($urandom_range(0, 4)) - 2;
					if ($urandom_range(0, 1))
						off = -off;
					other = ($urandom_range(0, 3) == 0) ?
						int'($urandom_range(0, 1 << 18)) - (1 << 17) : 0;
					p.bx = p.ax + (along_z ? other : off);
					p.bz = p.az + (along_z ? off : other);
				end
			endcase
			send_pair(p);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_not_eligible();
		test_circle_circle();
		test_circle_rect();
		test_rect_rect();
		test_random(500);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
